// ===== rtl/core/skt_pkg.sv =====
// Shared types, codes and sizes for the sorted key table.
package skt_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int TAG_W = 64;
  localparam int POS_W = 5;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } skt_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    logic [TAG_W-1:0] tag_out;
    logic [POS_W-1:0] occupancy;
  } skt_out_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic                    ins_en;
    logic                    del_en;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } skt_ctl_t;

endpackage

// ===== rtl/core/skt_cell.sv =====
// One entry of the sorted table: holds a key and tag, shifts with its neighbors.
module skt_cell (
  input  logic                            clk,
  input  skt_pkg::skt_ctl_t               ctl,
  input  logic                            occupied,
  input  logic                            le_in,
  input  logic                            seen_in,
  input  logic signed [skt_pkg::KEY_W-1:0] left_key,
  input  logic [skt_pkg::TAG_W-1:0]        left_tag,
  input  logic signed [skt_pkg::KEY_W-1:0] right_key,
  input  logic [skt_pkg::TAG_W-1:0]        right_tag,
  output logic                            le_out,
  output logic                            seen_out,
  output logic signed [skt_pkg::KEY_W-1:0] key_q,
  output logic [skt_pkg::TAG_W-1:0]        tag_q
);
  import skt_pkg::*;

  logic signed [KEY_W-1:0] key_r;
  logic [TAG_W-1:0]        tag_r;
  logic                    match;

  assign le_out   = occupied && (key_r <= ctl.key);
  assign match    = occupied && (key_r == ctl.key);
  assign seen_out = seen_in | match;
  assign key_q    = key_r;
  assign tag_q    = tag_r;

  // Insert: cells past the insertion point take the left neighbor, the first one
  // takes the new entry. Delete: cells from the first match on take the right one.
  always_ff @(posedge clk) begin
    if (ctl.ins_en && !le_out) begin
      if (le_in) begin
        key_r <= ctl.key;
        tag_r <= ctl.tag;
      end else begin
        key_r <= left_key;
        tag_r <= left_tag;
      end
    end else if (ctl.del_en && seen_out) begin
      key_r <= right_key;
      tag_r <= right_tag;
    end
  end

endmodule

// ===== rtl/core/sorted_key_table.sv =====
// Sorted key table top level: a chain of entry cells with control and result register.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one command item:
//   insert, search or delete of a signed 32-bit key, with a 64-bit tag for insert.
//   Result channel (out_valid / out_stall / out_item) returns exactly one result
//   item per command: status, 1-based position, tag and occupancy after the op.
//   Latency: the result is valid the cycle after the command is accepted.
//   Throughput: one command per cycle while in_stall is low. All cells compare the key in parallel
//   and shift with their neighbors in the same edge, so the table is updated
//   when the command is taken and the next command sees the new contents.
//   Reset (rst_n low, synchronous) empties the table and drops any pending
//   result; the entry contents themselves are not cleared, only the count.
//   Stall: while a result is held and out_stall is high, in_stall is raised
//   and no command is taken; the held result stays unchanged until taken.
//   A full table rejects an insert (status full); a missing key on search or
//   delete gives status not found. The unused command code answers ok with the
//   current occupancy and changes nothing.
module sorted_key_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  skt_pkg::skt_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output skt_pkg::skt_out_t out_item
);
  import skt_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  skt_out_t         out_item_r, out_item_nxt;

  logic                    accept;
  logic                    full;
  logic                    found;
  skt_ctl_t                ctl;
  logic [DEPTH-1:0]        occupied;
  logic [DEPTH:0]          le_c;
  logic [DEPTH:0]          seen_c;
  logic signed [KEY_W-1:0] key_q [DEPTH];
  logic [TAG_W-1:0]        tag_q [DEPTH];
  logic [POS_W-1:0]        pos_ins, pos_hit;
  logic [TAG_W-1:0]        tag_hit;

  // Hold the input off while a result waits on a stalled receiver.
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign found = seen_c[DEPTH];

  assign ctl.key    = in_item.key;
  assign ctl.tag    = in_item.tag;
  assign ctl.ins_en = accept && (in_item.cmd == CMD_INSERT) && !full;
  assign ctl.del_en = accept && (in_item.cmd == CMD_DELETE) && found;

  // Cell 0 sees an always-true "left is less or equal" and no earlier match.
  assign le_c[0]   = 1'b1;
  assign seen_c[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0] left_key, right_key;
    logic [TAG_W-1:0]        left_tag, right_tag;

    assign occupied[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_key = key_q[i];
      assign left_tag = tag_q[i];
    end else begin : g_mid_l
      assign left_key = key_q[i-1];
      assign left_tag = tag_q[i-1];
    end

    // The last cell has no right neighbor; on delete it keeps its own entry and the lowered count frees the tail.
    if (i == DEPTH - 1) begin : g_last
      assign right_key = key_q[i];
      assign right_tag = tag_q[i];
    end else begin : g_mid_r
      assign right_key = key_q[i+1];
      assign right_tag = tag_q[i+1];
    end

    skt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occupied[i]),
      .le_in     (le_c[i]),
      .seen_in   (seen_c[i]),
      .left_key  (left_key),
      .left_tag  (left_tag),
      .right_key (right_key),
      .right_tag (right_tag),
      .le_out    (le_c[i+1]),
      .seen_out  (seen_c[i+1]),
      .key_q     (key_q[i]),
      .tag_q     (tag_q[i])
    );
  end

  // Encode the insertion point (edge of the less-or-equal prefix) and the
  // first match (edge of the seen chain) into 1-based positions.
  always_comb begin
    pos_ins = '0;
    pos_hit = '0;
    tag_hit = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (le_c[i] && !le_c[i+1]) begin
        pos_ins = pos_ins | POS_W'(i + 1);
      end
      if (seen_c[i+1] && !seen_c[i]) begin
        pos_hit = pos_hit | POS_W'(i + 1);
        tag_hit = tag_hit | tag_q[i];
      end
    end
  end

  always_comb begin
    count_nxt             = count_r;
    out_item_nxt.status   = ST_OK;
    out_item_nxt.position = '0;
    out_item_nxt.tag_out  = '0;
    unique case (in_item.cmd)
      CMD_INSERT: begin
        if (full) begin
          out_item_nxt.status = ST_FULL;
        end else begin
          out_item_nxt.position = pos_ins;
          count_nxt             = count_r + CNT_W'(1);
        end
      end
      CMD_SEARCH, CMD_DELETE: begin
        if (!found) begin
          out_item_nxt.status = ST_NOT_FOUND;
        end else begin
          out_item_nxt.position = pos_hit;
          out_item_nxt.tag_out  = tag_hit;
          if (in_item.cmd == CMD_DELETE) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    out_item_nxt.occupancy = POS_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Advance the result register only when a command is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

// ===== tb/sv/sorted_key_table_chk.sv =====
// Scoreboard for the sorted key table: models the table, predicts each result and checks it.
`timescale 1ns / 100ps
module sorted_key_table_chk (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  skt_pkg::skt_in_t  in_item,
  input  logic              out_valid,
  input  logic              out_stall,
  input  skt_pkg::skt_out_t out_item,
  output int                fail_count,
  output int                pending
);
  import skt_pkg::*;

  logic signed [KEY_W-1:0] row_key [DEPTH];
  logic [TAG_W-1:0]        row_tag [DEPTH];
  int                      rows = 0;
  int                      errs = 0;
  skt_out_t                answer_q [$];

  // Apply one command to the modeled table and return the answer it gives.
  function automatic skt_out_t apply_command(skt_in_t c);
    skt_out_t r;
    int at;
    r = '0;
    at = 0;
    case (c.cmd)
      CMD_INSERT: begin
        if (rows >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // land after every key less than or equal to the new one
          while (at < rows && $signed(row_key[at]) <= $signed(c.key)) at++;
          for (int i = rows; i > at; i--) begin
            row_key[i] = row_key[i-1];
            row_tag[i] = row_tag[i-1];
          end
          row_key[at] = c.key;
          row_tag[at] = c.tag;
          rows++;
          r.position = POS_W'(at + 1);
        end
      end
      CMD_SEARCH, CMD_DELETE: begin
        while (at < rows && row_key[at] != c.key) at++;
        if (at == rows) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.position = POS_W'(at + 1);
          r.tag_out  = row_tag[at];
          if (c.cmd == CMD_DELETE) begin
            for (int i = at; i + 1 < rows; i++) begin
              row_key[i] = row_key[i+1];
              row_tag[i] = row_tag[i+1];
            end
            rows--;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = POS_W'(rows);
    return r;
  endfunction

  task automatic check_field(string name, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    skt_out_t want;
    if (!rst_n) begin
      rows = 0;
      answer_q.delete();
    end else begin
      // retire the oldest answer before taking this edge's command
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual %0h", $time, out_item);
          errs++;
        end else begin
          want = answer_q.pop_front();
          check_field("status", TAG_W'(want.status), TAG_W'(out_item.status));
          check_field("position", TAG_W'(want.position), TAG_W'(out_item.position));
          check_field("tag_out", want.tag_out, out_item.tag_out);
          check_field("occupancy", TAG_W'(want.occupancy), TAG_W'(out_item.occupancy));
        end
      end
      if (in_valid && !in_stall) answer_q.push_back(apply_command(in_item));
    end
    fail_count <= errs;
    pending    <= answer_q.size();
  end

endmodule

// ===== tb/sv/sorted_key_table_tb.sv =====
// Testbench top for the sorted key table: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 100ps
module sorted_key_table_tb;
  import skt_pkg::*;

  // The fourth command code is unused by the block: it must answer ok and change nothing.
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 500;
  localparam int PHASE_LEN    = 48;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_LIMIT  = 5000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  skt_in_t  in_item   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  skt_out_t out_item;
  int       fail_count;
  int       pending;
  int       sent_cnt  = 0;

  // Keys that recur often enough for searches and deletes to hit, extremes among them.
  logic signed [KEY_W-1:0] key_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_key_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  sorted_key_table_chk scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic skt_in_t mk(logic [1:0] c, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
    skt_in_t it;
    it.cmd = c;
    it.key = k;
    it.tag = t;
    return it;
  endfunction

  // Offer one item, hold it until the block takes it, then at random idle for a while.
  // Every third stretch of items runs back to back with no idling at all.
  task automatic issue(skt_in_t it);
    int n;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
    if ((sent_cnt / 40) % 3 == 1) n = 0;
    else if ($urandom_range(0, 9) == 0) n = $urandom_range(4, 20);
    else if ($urandom_range(0, 2) == 0) n = $urandom_range(1, 2);
    else n = 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Draw one command. Phase 0 fills the table, phase 1 drains it, phase 2 mixes.
  function automatic skt_in_t random_item(int phase);
    skt_in_t it;
    int r;
    int ins_cut;
    int srch_cut;
    int del_cut;
    r = $urandom_range(0, 99);
    case (phase)
      0:       begin ins_cut = 60; srch_cut = 80; del_cut = 95; end
      1:       begin ins_cut = 25; srch_cut = 50; del_cut = 95; end
      default: begin ins_cut = 35; srch_cut = 65; del_cut = 95; end
    endcase
    if (r < ins_cut) it.cmd = CMD_INSERT;
    else if (r < srch_cut) it.cmd = CMD_SEARCH;
    else if (r < del_cut) it.cmd = CMD_DELETE;
    else it.cmd = CMD_NOP;
    // mostly pooled keys so lookups hit; the rest spread over the full range
    if ($urandom_range(0, 4) == 0) it.key = $urandom;
    else it.key = key_pool[$urandom_range(0, 7)];
    it.tag = {$urandom, $urandom};
    return it;
  endfunction

  // Result side: free-running, random and long stall stretches. Once the sender is well
  // under way, hold off for a long stretch so the result backs up and the input stalls.
  initial begin
    int n;
    bit long_done;
    long_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_done && sent_cnt >= 80) begin
        long_done = 1'b1;
        n = $urandom_range(40, 70);
        repeat (n) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: repeat ($urandom_range(10, 40)) begin
            out_stall <= 1'b0;
            @(posedge clk);
          end
          3: repeat ($urandom_range(5, 15)) begin
            out_stall <= 1'b1;
            @(posedge clk);
          end
          default: repeat ($urandom_range(10, 30)) begin
            out_stall <= ($urandom_range(0, 3) == 0);
            @(posedge clk);
          end
        endcase
      end
    end
  end

  // Watchdog: end the run if it drags far past the slowest correct run.
  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int drain;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    key_pool[4] = 32'h0000_0001;
    for (int i = 5; i < 8; i++) key_pool[i] = $urandom;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: lookups on an empty table, extremes, duplicates, unused command,
    // a full table rejecting an insert, then removal of both ends.
    issue(mk(CMD_SEARCH, 32'd5, '0));
    issue(mk(CMD_DELETE, 32'd5, '1));
    issue(mk(CMD_INSERT, 32'h8000_0000, '1));
    issue(mk(CMD_INSERT, 32'h7fff_ffff, '0));
    issue(mk(CMD_INSERT, 32'h0000_0000, 64'h1111_1111_1111_1111));
    issue(mk(CMD_INSERT, 32'h0000_0000, 64'h2222_2222_2222_2222));
    issue(mk(CMD_SEARCH, 32'h0000_0000, '1));
    issue(mk(CMD_INSERT, 32'hffff_ffff, 64'h5a5a_5a5a_a5a5_a5a5));
    issue(mk(CMD_NOP, 32'h7fff_ffff, '1));
    issue(mk(CMD_DELETE, 32'h0000_0000, '0));
    issue(mk(CMD_SEARCH, 32'h0000_0000, '0));
    for (int i = 0; i < DEPTH - 4; i++) issue(mk(CMD_INSERT, $urandom, {$urandom, $urandom}));
    issue(mk(CMD_INSERT, 32'h0000_0001, '1));
    issue(mk(CMD_DELETE, 32'h8000_0000, '0));
    issue(mk(CMD_DELETE, 32'h7fff_ffff, '0));

    // Random: rotate through fill, drain and mixed phases; refresh part of the pool
    // at each phase so stored keys keep changing.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_LEN == 0) begin
        for (int j = 5; j < 8; j++) key_pool[j] = $urandom;
      end
      issue(random_item((i / PHASE_LEN) % 3));
    end
    in_valid <= 1'b0;

    // Step once so the scoreboard's count includes the last item, then drain.
    @(posedge clk);
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/skt_pkg.sv
rtl/core/skt_cell.sv
rtl/core/sorted_key_table.sv
tb/sv/sorted_key_table_chk.sv
tb/sv/sorted_key_table_tb.sv
